// ===== src/tcs_pkg.sv =====
// shared types and constants of the two-phase conductivity sequencer
// no dependencies; used by tcs_div, tcs_map and the top level
package tcs_pkg;

    // measurement phase as shown on the result word
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_CHECK = 3'd2,
        PH_POS   = 3'd3,
        PH_NEG   = 3'd4
    } phase_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_PASS_COUNT = 2'd0,
        REG_WAIT_TICKS = 2'd1
    } cfg_index_t;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PASS_CNT_W  = 10;
    localparam int TICK_W      = 16;
    localparam int ADC_FIELD_W = 12;
    localparam int RATIO_W     = 16;
    localparam int COND_W      = 15;
    localparam int COEF_W      = 13;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 24;

    localparam logic [PASS_CNT_W-1:0] PASS_COUNT_RST = 10'd64;
    localparam logic [TICK_W-1:0]     WAIT_TICKS_RST = 16'd10000;
    localparam logic [TICK_W-1:0]     TICK_MAX       = 16'hFFFF;

    // ratio is 10 * pos / neg in unsigned q8.8
    localparam logic [RATIO_W-1:0] RATIO_TEN = 16'd2560;
    localparam logic [RATIO_W-1:0] RATIO_SAT = 16'hFFFF;

    // piecewise map thresholds (q8.8)
    localparam logic [RATIO_W-1:0] THR_UPPER_LO = 16'd1103;
    localparam logic [RATIO_W-1:0] THR_TOP      = 16'd4352;
    localparam logic [RATIO_W-1:0] THR_BOTTOM   = 16'd717;
    localparam logic [RATIO_W-1:0] THR_LOWER_HI = 16'd1101;

    // segment slopes (q1.12) and offsets (q3.12)
    localparam logic [COEF_W-1:0] COEF_UPPER = 13'd205;
    localparam logic [COND_W-1:0] BASE_UPPER = 15'd3564;
    localparam logic [COEF_W-1:0] COEF_LOWER = 13'd5038;
    localparam logic [COND_W-1:0] BASE_LOWER = 15'd24740;
    localparam logic [COND_W-1:0] COND_MAX   = 15'd20480;

    typedef struct packed {
        logic               done;
        logic               none;
        logic [RATIO_W-1:0] ratio;
    } div_res_t;

    typedef struct packed {
        logic              done;
        logic              keep;
        logic [COND_W-1:0] value;
    } map_res_t;

endpackage

// ===== src/tcs_div.sv =====
// bit-serial restoring divider forming the saturated q8.8 ratio 2560*pos/neg
// one quotient bit per cycle; depends on tcs_pkg
module tcs_div #(
    parameter int SUM_W = 22
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_W-1:0]    pos_sum,
    input  logic [SUM_W-1:0]    neg_sum,
    output tcs_pkg::div_res_t   res
);
    import tcs_pkg::*;

    localparam int P5_W = SUM_W + 3;
    localparam int HI_W = SUM_W - 4;

    typedef enum logic [0:0] {D_IDLE, D_RUN} dstate_t;

    dstate_t            state_reg;
    logic [3:0]         cnt_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [SUM_W-1:0]   den_reg;
    logic [15:0]        lo_reg;
    logic [RATIO_W-1:0] q_reg;
    div_res_t           res_reg;

    logic [P5_W-1:0]    pos5;
    logic [HI_W-1:0]    num_hi;
    logic [15:0]        num_lo;
    logic [SUM_W:0]     trial;
    logic [SUM_W:0]     diff;
    logic               fits;
    logic [SUM_W-1:0]   rem_next;

    // 2560*pos = (5*pos) << 9; upper part seeds the remainder
    assign pos5   = P5_W'({pos_sum, 2'b00}) + P5_W'(pos_sum);
    assign num_hi = pos5[P5_W-1:7];
    assign num_lo = {pos5[6:0], 9'd0};

    assign trial    = {rem_reg, lo_reg[15]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= D_IDLE;
            res_reg.done <= 1'b0;
        end else begin
            res_reg.done <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        if (pos_sum == '0 && neg_sum == '0) begin
                            res_reg.done  <= 1'b1;
                            res_reg.none  <= 1'b1;
                            res_reg.ratio <= '0;
                        end else if (neg_sum == '0) begin
                            res_reg.done  <= 1'b1;
                            res_reg.none  <= 1'b0;
                            res_reg.ratio <= RATIO_TEN;
                        end else if ({4'd0, num_hi} >= neg_sum) begin
                            // quotient would not fit in 16 bits
                            res_reg.done  <= 1'b1;
                            res_reg.none  <= 1'b0;
                            res_reg.ratio <= RATIO_SAT;
                        end else begin
                            rem_reg   <= {4'd0, num_hi};
                            lo_reg    <= num_lo;
                            den_reg   <= neg_sum;
                            q_reg     <= '0;
                            cnt_reg   <= '0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    rem_reg <= rem_next;
                    lo_reg  <= {lo_reg[14:0], 1'b0};
                    q_reg   <= {q_reg[RATIO_W-2:0], fits};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        res_reg.done  <= 1'b1;
                        res_reg.none  <= 1'b0;
                        res_reg.ratio <= {q_reg[RATIO_W-2:0], fits};
                        state_reg     <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign res = res_reg;

endmodule

// ===== src/tcs_map.sv =====
// piecewise-linear map of the q8.8 ratio to q3.12 conductivity
// slope product by a shift-add multiplier, one ratio bit per cycle; depends on tcs_pkg
module tcs_map (
    input  logic              aclk,
    input  logic              aresetn,
    input  tcs_pkg::div_res_t div_res,
    output tcs_pkg::map_res_t res
);
    import tcs_pkg::*;

    localparam int ACC_W = COEF_W + RATIO_W;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_SUB} mstate_t;

    mstate_t            state_reg;
    logic [3:0]         cnt_reg;
    logic [COEF_W-1:0]  coef_reg;
    logic [COND_W-1:0]  base_reg;
    logic [RATIO_W-1:0] mr_reg;
    logic [ACC_W-1:0]   acc_reg;
    map_res_t           res_reg;

    logic [RATIO_W-1:0] r;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W:0]     rnd;
    logic [ACC_W-8:0]   scaled;

    assign r       = div_res.ratio;
    assign acc_sum = {1'b0, acc_reg} + (mr_reg[0] ? {1'b0, coef_reg, 16'd0} : '0);
    assign rnd     = {1'b0, acc_reg} + (ACC_W+1)'(128);
    assign scaled  = rnd[ACC_W:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= M_IDLE;
            res_reg.done <= 1'b0;
        end else begin
            res_reg.done <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (div_res.done) begin
                        if (div_res.none) begin
                            res_reg.done <= 1'b1;
                            res_reg.keep <= 1'b1;
                        end else if (r > THR_UPPER_LO && r < THR_TOP) begin
                            coef_reg  <= COEF_UPPER;
                            base_reg  <= BASE_UPPER;
                            mr_reg    <= r;
                            acc_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= M_MUL;
                        end else if (r > THR_BOTTOM && r < THR_LOWER_HI) begin
                            coef_reg  <= COEF_LOWER;
                            base_reg  <= BASE_LOWER;
                            mr_reg    <= r;
                            acc_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= M_MUL;
                        end else if (r >= THR_TOP) begin
                            res_reg.done  <= 1'b1;
                            res_reg.keep  <= 1'b0;
                            res_reg.value <= COND_MAX;
                        end else if (r <= THR_BOTTOM) begin
                            res_reg.done  <= 1'b1;
                            res_reg.keep  <= 1'b0;
                            res_reg.value <= '0;
                        end else begin
                            // ratio between the two segments
                            res_reg.done <= 1'b1;
                            res_reg.keep <= 1'b1;
                        end
                    end
                end
                M_MUL: begin
                    acc_reg <= acc_sum[ACC_W:1];
                    mr_reg  <= {1'b0, mr_reg[RATIO_W-1:1]};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_reg <= M_SUB;
                    end
                end
                M_SUB: begin
                    res_reg.done <= 1'b1;
                    res_reg.keep <= 1'b0;
                    if (scaled >= (ACC_W-7)'(base_reg)) begin
                        res_reg.value <= '0;
                    end else begin
                        res_reg.value <= base_reg - scaled[COND_W-1:0];
                    end
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign res = res_reg;

endmodule

// ===== src/two_phase_conductivity_sequencer.sv =====
// Two-phase conductivity measurement sequencer. Every input word gives exactly one
// result word. A word that does not end a measurement has its result word registered
// and offered in the next cycle; the next word is taken once the output is free.
// The word that ends a measurement runs the end-of-measurement arithmetic first: a
// bit-serial divider, after a load step, forms the q8.8 ratio, then a shift-add
// multiplier, after a decode step and followed by a subtract step, maps it to q3.12
// conductivity before its result is offered. Only the multiplier runs when the
// negative sum is zero, only the divider when the ratio lands on a flat segment or in
// the gap between the segments, and neither when both sums are zero or the ratio
// saturates. The input side is held off until that result word has been put out.
// Configuration registers: 0 pass_count (reset 64), 1 wait_ticks (reset 10000);
// write them only while no word is in flight.
// Depends on tcs_pkg, tcs_div and tcs_map.
module two_phase_conductivity_sequencer #(
    parameter int ADC_BITS   = 12,
    parameter int MAX_PASSES = 1023
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // ms_tick [0], peer_busy [1], adc_sample [13:2]
    input  logic [tcs_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // electrode_a [0], electrode_b [1], electrodes_enabled [2], phase [5:3],
    // conductivity [20:6]
    output logic [tcs_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [tcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tcs_pkg::*;

    localparam int SAMPLE_W = (ADC_BITS < ADC_FIELD_W) ? ADC_BITS : ADC_FIELD_W;
    localparam int CNT_W    = $clog2(MAX_PASSES + 1);
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int LIM_W    = (CNT_W > PASS_CNT_W) ? CNT_W : PASS_CNT_W;

    typedef enum logic [1:0] {ST_IN, ST_CALC, ST_EMIT} state_t;

    state_t                state_reg,      state_next;
    logic [PASS_CNT_W-1:0] pass_count_reg;
    logic [TICK_W-1:0]     wait_ticks_reg;
    phase_t                phase_reg,      phase_next;
    logic [TICK_W-1:0]     tick_reg,       tick_next;
    logic [CNT_W-1:0]      passes_reg,     passes_next;
    logic [SUM_W-1:0]      pos_reg,        pos_next;
    logic [SUM_W-1:0]      neg_reg,        neg_next;
    logic [COND_W-1:0]     cond_reg,       cond_next;
    logic                  drive_a_reg,    drive_a_next;
    logic                  drive_b_reg,    drive_b_next;
    logic                  pins_reg,       pins_next;
    logic                  m_tvalid_reg,   m_tvalid_next;
    logic [M_DATA_W-1:0]   m_data_reg,     m_data_next;
    logic                  m_last_reg,     m_last_next;

    logic                  ms_tick;
    logic                  peer_busy;
    logic [SAMPLE_W-1:0]   sample;
    logic                  s_accept;
    logic                  out_free;
    logic                  finish;
    logic [TICK_W-1:0]     tick_inc;
    logic [LIM_W-1:0]      limit;
    logic                  more_passes;
    div_res_t              div_res;
    map_res_t              map_res;

    function automatic logic [M_DATA_W-1:0] pack_word(
        input logic              a,
        input logic              b,
        input logic              en,
        input phase_t            ph,
        input logic [COND_W-1:0] cond
    );
        return M_DATA_W'({cond, ph, en, b, a});
    endfunction

    assign ms_tick   = s_tdata[0];
    assign peer_busy = s_tdata[1];
    assign sample    = s_tdata[2 +: SAMPLE_W];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IN) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign tick_inc = (ms_tick && tick_reg != TICK_MAX) ? tick_reg + 1'b1 : tick_reg;
    assign limit    = (LIM_W'(pass_count_reg) < LIM_W'(MAX_PASSES)) ?
                      LIM_W'(pass_count_reg) : LIM_W'(MAX_PASSES);
    assign more_passes = LIM_W'(passes_reg) < limit;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        passes_next  = passes_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        cond_next    = cond_reg;
        drive_a_next = drive_a_reg;
        drive_b_next = drive_b_reg;
        pins_next    = pins_reg;
        finish       = 1'b0;

        if (s_accept) begin
            unique case (phase_reg)
                PH_WAIT: begin
                    tick_next = tick_inc;
                    if (tick_inc >= wait_ticks_reg) begin
                        pins_next   = 1'b1;
                        pos_next    = '0;
                        neg_next    = '0;
                        passes_next = '0;
                        phase_next  = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    drive_a_next = 1'b0;
                    if (more_passes) begin
                        drive_b_next = 1'b1;
                        phase_next   = PH_POS;
                    end else begin
                        drive_b_next = 1'b0;
                        phase_next   = PH_IDLE;
                        finish       = 1'b1;
                    end
                end
                PH_POS: begin
                    pos_next     = pos_reg + SUM_W'(sample);
                    drive_a_next = 1'b1;
                    drive_b_next = 1'b0;
                    phase_next   = PH_NEG;
                end
                PH_NEG: begin
                    neg_next     = neg_reg + SUM_W'(sample);
                    drive_a_next = 1'b0;
                    pins_next    = 1'b1;
                    passes_next  = passes_reg + 1'b1;
                    phase_next   = PH_CHECK;
                end
                default: begin
                    if (!peer_busy) begin
                        tick_next  = '0;
                        phase_next = PH_WAIT;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end

        // output word: plain items go out at once, a finishing item after the math
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        unique case (state_reg)
            ST_IN: begin
                if (s_accept) begin
                    if (finish) begin
                        state_next = ST_CALC;
                    end else begin
                        m_data_next   = pack_word(drive_a_next, drive_b_next, pins_next,
                                                  phase_next, cond_reg);
                        m_last_next   = 1'b0;
                        m_tvalid_next = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                if (map_res.done) begin
                    if (!map_res.keep) begin
                        cond_next = map_res.value;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_data_next   = pack_word(drive_a_reg, drive_b_reg, pins_reg,
                                              phase_reg, cond_reg);
                    m_last_next   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IN;
                end
            end
            default: state_next = ST_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IN;
            pass_count_reg <= PASS_COUNT_RST;
            wait_ticks_reg <= WAIT_TICKS_RST;
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            passes_reg     <= '0;
            pos_reg        <= '0;
            neg_reg        <= '0;
            cond_reg       <= '0;
            drive_a_reg    <= 1'b0;
            drive_b_reg    <= 1'b0;
            pins_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            passes_reg   <= passes_next;
            pos_reg      <= pos_next;
            neg_reg      <= neg_next;
            cond_reg     <= cond_next;
            drive_a_reg  <= drive_a_next;
            drive_b_reg  <= drive_b_next;
            pins_reg     <= pins_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                if (cfg_addr == REG_PASS_COUNT) begin
                    pass_count_reg <= cfg_wdata[PASS_CNT_W-1:0];
                end else if (cfg_addr == REG_WAIT_TICKS) begin
                    wait_ticks_reg <= cfg_wdata[TICK_W-1:0];
                end
            end
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    tcs_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept && finish),
        .pos_sum (pos_reg),
        .neg_sum (neg_reg),
        .res     (div_res)
    );

    tcs_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_res (div_res),
        .res     (map_res)
    );

    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    a_div_only_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == ST_CALC)
        else $error("divider finished outside a calculation");

    a_map_only_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        map_res.done |-> state_reg == ST_CALC)
        else $error("mapper finished outside a calculation");

    a_finish_enters_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && finish) |=> (state_reg == ST_CALC && phase_reg == PH_IDLE))
        else $error("finishing word did not start the calculation");

    a_last_word_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5:3] == PH_IDLE && m_tdata[1:0] == 2'b00))
        else $error("measurement end word not idle with electrodes low");

    a_pos_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_POS) |-> (!drive_a_reg && drive_b_reg && pins_reg))
        else $error("positive phase with wrong electrode drive");

    a_passes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        LIM_W'(passes_reg) <= LIM_W'(MAX_PASSES))
        else $error("pass counter beyond its limit");
`endif

endmodule
